@@ hdl/ffsa_pkg.sv @@
// Shared constants and codes of the first-fit segment allocator.
package ffsa_pkg;

	localparam int MAX_SEGMENTS_DFLT = 64;
	localparam int ADDR_BITS_DFLT    = 32;

	localparam int FIELD_W = 32;
	localparam int COUNT_W = 7;

	localparam logic [FIELD_W-1:0] REGION_RESET = 32'd4194304;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

endpackage

@@ hdl/ffsa_table.sv @@
// Segment table memory: one write port and one registered read port.
module ffsa_table #(
	parameter int AW    = 32,
	parameter int DEPTH = 64,
	localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output logic [AW-1:0] rd_start,
	output logic [AW-1:0] rd_len,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  logic [AW-1:0] wr_start,
	input  logic [AW-1:0] wr_len
);

	logic [2*AW-1:0] mem [DEPTH];
	logic [2*AW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_start, wr_len};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_start = rd_data_q[2*AW-1:AW];
	assign rd_len   = rd_data_q[AW-1:0];

endmodule

@@ hdl/first_fit_segment_allocator.sv @@
// Top level of the first-fit segment allocator.
//
// The block keeps a table of taken segments of one byte region, sorted by
// offset. A request enters on the input channel (in_valid, in_ready) with
// cmd, req_size and free_offset; one result per request leaves on the
// output channel (out_valid, out_ready) with ok, placed_offset, used_count
// and now_empty. The user writes the region size through cfg_wen and
// cfg_wdata only while the block is idle; the block does not enforce it.
// A request is handled by a sequencer around one subtract and compare unit
// and a single-port read, single-port write table memory. Scanning reads
// and then compares each table entry visited, and inserting or removing a
// segment reads and then writes back each entry that moves, one place over.
// One request is in flight at a time; in_ready is high only while the
// sequencer is idle. The result sits in an output register, so a new
// request is taken while it waits; a stalled receiver holds the next result
// in the sequencer until the output register frees up.
// Reset empties the table and sets the region to 4194304 bytes; no memory
// clearing pass is needed.
module first_fit_segment_allocator
	import ffsa_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DFLT,
	parameter int ADDR_BITS    = ADDR_BITS_DFLT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [FIELD_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [FIELD_W-1:0] req_size,
	input  logic [FIELD_W-1:0] free_offset,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               ok,
	output logic [FIELD_W-1:0] placed_offset,
	output logic [COUNT_W-1:0] used_count,
	output logic               now_empty
);

	localparam int AW = ADDR_BITS;
	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_SEGMENTS);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_RD     = 8'b0000_0010,
		S_CMP    = 8'b0000_0100,
		S_TAIL   = 8'b0000_1000,
		S_MVRD   = 8'b0001_0000,
		S_MVWR   = 8'b0010_0000,
		S_COMMIT = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t        state_q;
	logic          cmd_q;
	logic [AW-1:0] size_q;
	logic [AW-1:0] offs_q;
	logic [AW-1:0] region_q;
	logic [AW:0]   cursor_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] mv_q;
	logic [CW-1:0] count_q;
	logic          ok_q;
	logic [AW:0]   placed_q;

	logic               out_valid_q;
	logic               out_ok_q;
	logic [FIELD_W-1:0] out_placed_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_empty_q;

	logic [AW-1:0] tbl_start;
	logic [AW-1:0] tbl_len;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [AW-1:0] wr_start;
	logic [AW-1:0] wr_len;

	logic [AW-1:0] size_in;
	logic          in_fire;
	logic          out_load;
	logic [CW-1:0] idx_nxt;
	logic [CW-1:0] mv_src;
	logic [AW-1:0] sub_a;
	logic [AW+1:0] room;
	logic          fits;
	logic [AW:0]   seg_end;

	assign size_in  = AW'(req_size);
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign idx_nxt  = idx_q + 1'b1;
	assign mv_src   = (cmd_q == CMD_FREE) ? (mv_q + 1'b1) : (mv_q - 1'b1);

	// Shared unit: room in front of a segment, or behind the last one.
	assign sub_a   = (state_q == S_TAIL) ? region_q : tbl_start;
	assign room    = {2'b00, sub_a} - {1'b0, cursor_q};
	assign fits    = !room[AW+1] && ({2'b00, size_q} <= room);
	assign seg_end = {1'b0, tbl_start} + {1'b0, tbl_len};

	assign rd_en    = (state_q == S_RD) || (state_q == S_MVRD);
	assign rd_addr  = (state_q == S_MVRD) ? mv_src[IW-1:0] : idx_q[IW-1:0];
	assign wr_en    = (state_q == S_MVWR) || ((state_q == S_COMMIT) && (cmd_q == CMD_ALLOC));
	assign wr_addr  = (state_q == S_MVWR) ? mv_q[IW-1:0] : pos_q[IW-1:0];
	assign wr_start = (state_q == S_MVWR) ? tbl_start : cursor_q[AW-1:0];
	assign wr_len   = (state_q == S_MVWR) ? tbl_len : size_q;

	ffsa_table #(
		.AW    (AW),
		.DEPTH (MAX_SEGMENTS)
	) u_table (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_start (tbl_start),
		.rd_len   (tbl_len),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_start (wr_start),
		.wr_len   (wr_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= AW'(REGION_RESET);
		end else if (cfg_wen) begin
			region_q <= AW'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (cmd == CMD_FREE) begin
							state_q <= (count_q == '0) ? S_DONE : S_RD;
						end else if ((size_in == '0) || (count_q == COUNT_MAX)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= (count_q == '0) ? S_TAIL : S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (cmd_q == CMD_FREE) begin
						if (tbl_start == offs_q) begin
							state_q <= (idx_nxt == count_q) ? S_COMMIT : S_MVRD;
						end else begin
							state_q <= (idx_nxt == count_q) ? S_DONE : S_RD;
						end
					end else if (fits) begin
						state_q <= S_MVRD;
					end else begin
						state_q <= (idx_nxt == count_q) ? S_TAIL : S_RD;
					end
				end
				S_TAIL: begin
					state_q <= fits ? S_COMMIT : S_DONE;
				end
				S_MVRD: begin
					state_q <= S_MVWR;
				end
				S_MVWR: begin
					if (cmd_q == CMD_FREE) begin
						state_q <= ((mv_src + 1'b1) == count_q) ? S_COMMIT : S_MVRD;
					end else begin
						state_q <= (mv_src == pos_q) ? S_COMMIT : S_MVRD;
					end
				end
				S_COMMIT: begin
					count_q <= (cmd_q == CMD_FREE) ? (count_q - 1'b1) : (count_q + 1'b1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q    <= cmd;
				size_q   <= size_in;
				offs_q   <= AW'(free_offset);
				cursor_q <= '0;
				idx_q    <= '0;
				ok_q     <= 1'b0;
				placed_q <= '0;
				pos_q    <= count_q;
			end
			S_CMP: begin
				idx_q <= idx_nxt;
				if (cmd_q == CMD_FREE) begin
					mv_q <= idx_q;
				end else if (fits) begin
					pos_q <= idx_q;
					mv_q  <= count_q;
				end else begin
					cursor_q <= seg_end;
				end
			end
			S_MVWR: begin
				mv_q <= mv_src;
			end
			S_COMMIT: begin
				ok_q <= 1'b1;
				if (cmd_q == CMD_ALLOC) begin
					placed_q <= cursor_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q     <= ok_q;
			out_placed_q <= FIELD_W'(placed_q);
			out_count_q  <= COUNT_W'(count_q);
			out_empty_q  <= (count_q == '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = out_ok_q;
	assign placed_offset = out_placed_q;
	assign used_count    = out_count_q;
	assign now_empty     = out_empty_q;

endmodule

@@ hdl/ffsa_checker.sv @@
// Port-level checker of the first-fit segment allocator and its bind.
module ffsa_checker
	import ffsa_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               ok,
	input logic [FIELD_W-1:0] placed_offset,
	input logic [COUNT_W-1:0] used_count,
	input logic               now_empty
);

	// One transaction is worked on at a time, so the input closes after it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready stayed high after an accepted transaction");

	a_empty_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (now_empty == (used_count == '0)))
		else $error("now_empty disagrees with used_count");

	a_fail_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (placed_offset == '0))
		else $error("failed transaction reports a nonzero offset");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(placed_offset)
			&& $stable(used_count) && $stable(ok)))
		else $error("stalled result changed or dropped");

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.ok            (ok),
	.placed_offset (placed_offset),
	.used_count    (used_count),
	.now_empty     (now_empty)
);

@@ tb/sv/first_fit_segment_allocator_tb.sv @@
// Self-checking testbench of the first-fit segment allocator with driver, monitor and predictor.
module first_fit_segment_allocator_tb;
	import ffsa_pkg::*;

	localparam int MAX_SEG       = MAX_SEGMENTS_DFLT;
	localparam int MDL_CHECK     = 0;
	localparam int MDL_PLAN      = 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 300;
	localparam int QUIET_LIMIT   = 4000;
	localparam int REPORT_CAP    = 50;

	typedef struct packed {
		logic               cmd;
		logic [FIELD_W-1:0] size;
		logic [FIELD_W-1:0] offset;
	} request_t;

	typedef struct packed {
		logic               ok;
		logic [FIELD_W-1:0] offset;
		logic [COUNT_W-1:0] count;
		logic               empty;
	} outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wen = 1'b0;
	logic [FIELD_W-1:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               cmd = CMD_ALLOC;
	logic [FIELD_W-1:0] req_size = '0;
	logic [FIELD_W-1:0] free_offset = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               ok;
	logic [FIELD_W-1:0] placed_offset;
	logic [COUNT_W-1:0] used_count;
	logic               now_empty;

	// Two copies of the segment table: one tracks the block for checking, one
	// tracks the table as stimulus is planned so frees can target live segments.
	logic [63:0] seg_base [2][MAX_SEG];
	logic [63:0] seg_size [2][MAX_SEG];
	int          seg_total [2] = '{0, 0};
	logic [63:0] region_len [2] = '{64'(REGION_RESET), 64'(REGION_RESET)};

	request_t    pending_requests [$];
	outcome_t    expected_outcomes [$];
	request_t    next_request;
	outcome_t    want;
	int          mismatches = 0;
	int unsigned tick = 0;
	int unsigned quiet_cycles = 0;

	first_fit_segment_allocator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.req_size     (req_size),
		.free_offset  (free_offset),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ok           (ok),
		.placed_offset(placed_offset),
		.used_count   (used_count),
		.now_empty    (now_empty)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic outcome_t serve_request(input int m, input logic op,
			input logic [FIELD_W-1:0] sz, input logic [FIELD_W-1:0] off);
		outcome_t    res;
		logic [63:0] cursor;
		logic [63:0] gap;
		logic [63:0] tail;
		logic        hit;
		int          pos;
		int          i;
		res = '0;
		cursor = '0;
		hit = 1'b0;
		pos = seg_total[m];
		if (op == CMD_ALLOC) begin
			if (sz != 0 && seg_total[m] < MAX_SEG) begin
				for (i = 0; i < seg_total[m] && !hit; i++) begin
					gap = (seg_base[m][i] >= cursor) ? seg_base[m][i] - cursor : 64'd0;
					if (64'(sz) <= gap) begin
						hit = 1'b1;
						pos = i;
					end else begin
						cursor = seg_base[m][i] + seg_size[m][i];
					end
				end
				res.ok = 1'b1;
				if (!hit) begin
					tail = (region_len[m] >= cursor) ? region_len[m] - cursor : 64'd0;
					if (64'(sz) > tail)
						res.ok = 1'b0;
				end
				if (res.ok) begin
					for (i = seg_total[m]; i > pos; i--) begin
						seg_base[m][i] = seg_base[m][i-1];
						seg_size[m][i] = seg_size[m][i-1];
					end
					seg_base[m][pos] = cursor;
					seg_size[m][pos] = 64'(sz);
					seg_total[m]++;
					res.offset = cursor[FIELD_W-1:0];
				end
			end
		end else begin
			for (i = 0; i < seg_total[m] && !hit; i++) begin
				if (seg_base[m][i] == 64'(off)) begin
					hit = 1'b1;
					pos = i;
				end
			end
			if (hit) begin
				for (i = pos; i + 1 < seg_total[m]; i++) begin
					seg_base[m][i] = seg_base[m][i+1];
					seg_size[m][i] = seg_size[m][i+1];
				end
				seg_total[m]--;
				res.ok = 1'b1;
			end
		end
		res.count = COUNT_W'(seg_total[m]);
		res.empty = (seg_total[m] == 0);
		return res;
	endfunction

	function automatic logic [63:0] plan_tail();
		logic [63:0] last_end;
		last_end = '0;
		if (seg_total[MDL_PLAN] > 0)
			last_end = seg_base[MDL_PLAN][seg_total[MDL_PLAN]-1]
				+ seg_size[MDL_PLAN][seg_total[MDL_PLAN]-1];
		return (region_len[MDL_PLAN] >= last_end) ? region_len[MDL_PLAN] - last_end : 64'd0;
	endfunction

	// Random holdoff on both channels, except in a long calm window that recurs as tick advances.
	function automatic logic lull();
		if (tick % 8000 < 1500)
			return 1'b0;
		return ($urandom_range(0, 99) < 25);
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < REPORT_CAP)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [FIELD_W-1:0] got,
			input logic [FIELD_W-1:0] exp);
		if (got !== exp)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp));
	endtask

	task automatic push_request(input logic op, input logic [FIELD_W-1:0] sz,
			input logic [FIELD_W-1:0] off);
		void'(serve_request(MDL_PLAN, op, sz, off));
		pending_requests.push_back('{cmd: op, size: sz, offset: off});
	endtask

	task automatic push_random(input int unsigned size_cap, input int unsigned free_pct);
		int unsigned r;
		logic [63:0] tail;
		logic [FIELD_W-1:0] pick;
		r = $urandom_range(0, 99);
		if (r < free_pct) begin
			if (seg_total[MDL_PLAN] > 0 && $urandom_range(0, 9) < 8) begin
				pick = seg_base[MDL_PLAN][$urandom_range(0, seg_total[MDL_PLAN] - 1)][31:0];
				push_request(CMD_FREE, $urandom, pick);
			end else if (seg_total[MDL_PLAN] > 0 && $urandom_range(0, 1) == 0) begin
				pick = seg_base[MDL_PLAN][$urandom_range(0, seg_total[MDL_PLAN] - 1)][31:0];
				push_request(CMD_FREE, $urandom, pick + 32'd1);
			end else begin
				push_request(CMD_FREE, $urandom, $urandom);
			end
		end else begin
			r = $urandom_range(0, 99);
			tail = plan_tail();
			if (r < 3)
				push_request(CMD_ALLOC, '0, $urandom);
			else if (r < 8)
				push_request(CMD_ALLOC, $urandom, $urandom);
			else if (r < 13 && tail != 0 && tail <= 64'hFFFF_FFFF)
				push_request(CMD_ALLOC, tail[31:0], $urandom);
			else
				push_request(CMD_ALLOC, $urandom_range(1, size_cap), $urandom);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_outcomes.size() != 0);
	endtask

	task automatic run_phase(input logic [FIELD_W-1:0] region, input int unsigned size_cap,
			input int unsigned free_pct, input int n);
		int k;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= region;
		@(posedge clk);
		cfg_wen <= 1'b0;
		region_len[MDL_CHECK] = 64'(region);
		region_len[MDL_PLAN] = 64'(region);
		@(negedge clk);
		for (k = 0; k < n; k++)
			push_random((size_cap == 0) ? 1 : size_cap, free_pct);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				expected_outcomes.push_back(serve_request(MDL_CHECK, cmd, req_size,
					free_offset));
			if (pending_requests.size() != 0 && !lull()) begin
				next_request = pending_requests.pop_front();
				in_valid <= 1'b1;
				cmd <= next_request.cmd;
				req_size <= next_request.size;
				free_offset <= next_request.offset;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("result with no transaction waiting");
				end else begin
					want = expected_outcomes.pop_front();
					compare_field("ok", 32'(ok), 32'(want.ok));
					compare_field("placed_offset", placed_offset, want.offset);
					compare_field("used_count", 32'(used_count), 32'(want.count));
					compare_field("now_empty", 32'(now_empty), 32'(want.empty));
				end
			end
			out_ready <= !lull();
		end
	end

	always @(posedge clk) begin
		tick <= tick + 1;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [FIELD_W-1:0] rnd_region;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Directed sequence on the reset region size.
		push_request(CMD_FREE, $urandom, 32'd0);
		push_request(CMD_ALLOC, 32'd0, $urandom);
		push_request(CMD_ALLOC, 32'hFFFF_FFFF, $urandom);
		push_request(CMD_ALLOC, REGION_RESET, $urandom);
		push_request(CMD_ALLOC, 32'd1, $urandom);
		push_request(CMD_FREE, $urandom, 32'd0);
		push_request(CMD_ALLOC, 32'd100, $urandom);
		push_request(CMD_ALLOC, 32'd200, $urandom);
		push_request(CMD_ALLOC, 32'd300, $urandom);
		push_request(CMD_FREE, $urandom, 32'd100);
		push_request(CMD_ALLOC, 32'd250, $urandom);
		push_request(CMD_ALLOC, 32'd200, $urandom);
		push_request(CMD_FREE, $urandom, 32'd50);
		push_request(CMD_FREE, $urandom, 32'hFFFF_FFFF);
		push_request(CMD_FREE, $urandom, 32'd600);
		push_request(CMD_ALLOC, REGION_RESET - 32'd600, $urandom);
		push_request(CMD_ALLOC, 32'd1, $urandom);
		push_request(CMD_FREE, $urandom, 32'd0);
		push_request(CMD_ALLOC, 32'd101, $urandom);
		push_request(CMD_ALLOC, 32'd100, $urandom);

		run_phase(32'd0, 16, 30, 40);
		run_phase(32'hFFFF_FFFF, 4096, 5, 100);
		run_phase(32'd4096, 512, 45, 80);
		run_phase(32'd1, 1, 40, 40);
		rnd_region = $urandom;
		run_phase(rnd_region, rnd_region >> 4, 35, 80);
		run_phase(REGION_RESET, 65536, 40, 80);
		run_phase(32'd65536, 2048, 35, 80);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
